/* hw/rtl/ls6502_pkg.sv */
// shared types, constants and opcode decode for the load/store core
`default_nettype none
package ls6502_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_RESET = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_NOP = 3'd0,
    OP_LDA = 3'd1,
    OP_LDX = 3'd2,
    OP_LDY = 3'd3,
    OP_STA = 3'd4,
    OP_STX = 3'd5,
    OP_STY = 3'd6,
    OP_HLT = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    AM_IMP = 4'd0,
    AM_IMM = 4'd1,
    AM_ZP  = 4'd2,
    AM_ZPX = 4'd3,
    AM_ZPY = 4'd4,
    AM_ABS = 4'd5,
    AM_ABX = 4'd6,
    AM_ABY = 4'd7,
    AM_INX = 4'd8,
    AM_INY = 4'd9
  } am_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RST_HI,
    S_RST_LO,
    S_RST_FETCH
  } seq_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  p;
    logic [7:0]  s;
    logic [7:0]  dl;
    logic [15:0] al;
    logic        halt;
    op_t         op;
    am_t         ak;
    logic [1:0]  step;
    logic        ar;
    logic        pse;
    logic        fse;
    logic        exe;
  } core_t;

  typedef struct packed {
    op_t  op;
    am_t  ak;
    logic pse;
    logic fse;
  } dec_t;

  localparam logic [15:0] VEC_LO  = 16'hfffc;
  localparam logic [15:0] VEC_HI  = 16'hfffd;
  localparam logic [7:0]  SP_INIT = 8'hfd;
  localparam logic [7:0]  P_INIT  = 8'h24;

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t d;
    d = '{op: OP_NOP, ak: AM_IMP, pse: 1'b0, fse: 1'b0};
    unique case (opc)
      8'h02, 8'h12, 8'h22, 8'h32, 8'h42, 8'h52,
      8'h62, 8'h72, 8'h92, 8'hb2, 8'hd2, 8'hf2: d.op = OP_HLT;
      8'ha9: begin d.op = OP_LDA; d.ak = AM_IMM; end
      8'ha5: begin d.op = OP_LDA; d.ak = AM_ZP;  end
      8'hb5: begin d.op = OP_LDA; d.ak = AM_ZPX; end
      8'had: begin d.op = OP_LDA; d.ak = AM_ABS; end
      8'hbd: begin d.op = OP_LDA; d.ak = AM_ABX; d.pse = 1'b1; end
      8'hb9: begin d.op = OP_LDA; d.ak = AM_ABY; d.pse = 1'b1; end
      8'ha1: begin d.op = OP_LDA; d.ak = AM_INX; end
      8'hb1: begin d.op = OP_LDA; d.ak = AM_INY; d.pse = 1'b1; end
      8'ha2: begin d.op = OP_LDX; d.ak = AM_IMM; end
      8'ha6: begin d.op = OP_LDX; d.ak = AM_ZP;  end
      8'hb6: begin d.op = OP_LDX; d.ak = AM_ZPY; end
      8'hae: begin d.op = OP_LDX; d.ak = AM_ABS; end
      8'hbe: begin d.op = OP_LDX; d.ak = AM_ABY; d.pse = 1'b1; end
      8'ha0: begin d.op = OP_LDY; d.ak = AM_IMM; end
      8'ha4: begin d.op = OP_LDY; d.ak = AM_ZP;  end
      8'hb4: begin d.op = OP_LDY; d.ak = AM_ZPX; end
      8'hac: begin d.op = OP_LDY; d.ak = AM_ABS; end
      8'hbc: begin d.op = OP_LDY; d.ak = AM_ABX; d.pse = 1'b1; end
      8'h85: begin d.op = OP_STA; d.ak = AM_ZP;  end
      8'h95: begin d.op = OP_STA; d.ak = AM_ZPX; end
      8'h8d: begin d.op = OP_STA; d.ak = AM_ABS; end
      8'h9d: begin d.op = OP_STA; d.ak = AM_ABX; d.fse = 1'b1; end
      8'h99: begin d.op = OP_STA; d.ak = AM_ABY; d.fse = 1'b1; end
      8'h81: begin d.op = OP_STA; d.ak = AM_INX; end
      8'h91: begin d.op = OP_STA; d.ak = AM_INY; d.fse = 1'b1; end
      8'h86: begin d.op = OP_STX; d.ak = AM_ZP;  end
      8'h96: begin d.op = OP_STX; d.ak = AM_ZPY; end
      8'h8e: begin d.op = OP_STX; d.ak = AM_ABS; end
      8'h84: begin d.op = OP_STY; d.ak = AM_ZP;  end
      8'h94: begin d.op = OP_STY; d.ak = AM_ZPX; end
      8'h8c: begin d.op = OP_STY; d.ak = AM_ABS; end
      default: d.op = OP_NOP;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ls6502_mem.sv */
// byte memory, one port, registered read
`default_nettype none
module ls6502_mem #(
  parameter int ADDR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [7:0]           wd,
  output logic      [7:0]           rd
);

  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end

endmodule
`default_nettype wire

/* hw/rtl/ls6502_exec.sv */
// bus cycle logic: memory access of a tick and the state after it
`default_nettype none
module ls6502_exec (
  input  wire ls6502_pkg::core_t cur,
  input  wire logic [7:0]        rd,
  output logic [15:0]            iss_addr,
  output logic                   iss_we,
  output logic [7:0]             iss_wd,
  output ls6502_pkg::core_t      tick_nxt,
  output ls6502_pkg::core_t      fetch_nxt,
  output logic                   tick_ret
);

  function automatic ls6502_pkg::core_t do_fetch(input ls6502_pkg::core_t s,
                                                 input logic [7:0] opc);
    ls6502_pkg::core_t r;
    ls6502_pkg::dec_t  d;
    r      = s;
    d      = ls6502_pkg::decode(opc);
    r.pc   = s.pc + 16'd1;
    r.op   = d.op;
    r.ak   = d.ak;
    r.pse  = d.pse;
    r.fse  = d.fse;
    r.step = 2'd0;
    r.ar   = 1'b0;
    r.exe  = 1'b0;
    return r;
  endfunction

  logic store_ok;

  // memory access issued at the start of the tick
  always_comb begin
    iss_addr = cur.pc;
    iss_we   = 1'b0;
    iss_wd   = cur.a;
    store_ok = 1'b0;
    if (!cur.halt) begin
      if (cur.ar) begin
        iss_addr = cur.exe ? cur.pc : cur.al;
        store_ok = !cur.exe;
      end else begin
        unique case (cur.ak)
          ls6502_pkg::AM_IMM, ls6502_pkg::AM_ZP, ls6502_pkg::AM_ZPX,
          ls6502_pkg::AM_ZPY, ls6502_pkg::AM_ABS, ls6502_pkg::AM_ABX,
          ls6502_pkg::AM_ABY: iss_addr = cur.pc;
          ls6502_pkg::AM_INX: iss_addr = cur.step[1] ? {8'd0, cur.dl} : cur.pc;
          ls6502_pkg::AM_INY: iss_addr = (cur.step == 2'd0) ? cur.pc : {8'd0, cur.dl};
          default: begin
            iss_addr = cur.al;
            store_ok = !cur.exe;
          end
        endcase
      end
    end
    if (store_ok) begin
      unique case (cur.op)
        ls6502_pkg::OP_STA: begin iss_we = 1'b1; iss_wd = cur.a; end
        ls6502_pkg::OP_STX: begin iss_we = 1'b1; iss_wd = cur.x; end
        ls6502_pkg::OP_STY: begin iss_we = 1'b1; iss_wd = cur.y; end
        default: iss_we = 1'b0;
      endcase
    end
  end

  assign fetch_nxt = do_fetch(cur, rd);

  logic        fire;
  logic        idx_en;
  logic [1:0]  first;
  logic [7:0]  idx;
  logic [15:0] base;
  logic [8:0]  low_sum;
  logic        stall;

  always_comb begin
    tick_nxt = cur;
    tick_ret = 1'b0;
    fire     = 1'b0;
    idx_en   = 1'b0;
    first    = 2'd1;
    idx      = cur.x;
    base     = cur.al;
    low_sum  = 9'd0;
    stall    = 1'b0;
    if (!cur.halt) begin
      if (cur.ar) begin
        fire = 1'b1;
      end else begin
        unique case (cur.ak)
          ls6502_pkg::AM_IMM: begin
            tick_nxt.al = cur.pc;
            tick_nxt.ar = 1'b1;
            tick_nxt.pc = cur.pc + 16'd1;
            fire        = 1'b1;
          end
          ls6502_pkg::AM_ZP: begin
            tick_nxt.al = {8'd0, rd};
            tick_nxt.ar = 1'b1;
            tick_nxt.pc = cur.pc + 16'd1;
          end
          ls6502_pkg::AM_ZPX, ls6502_pkg::AM_ZPY: begin
            if (cur.step == 2'd0) begin
              tick_nxt.dl = rd;
              tick_nxt.pc = cur.pc + 16'd1;
            end else begin
              tick_nxt.al = {8'd0, cur.dl +
                             ((cur.ak == ls6502_pkg::AM_ZPX) ? cur.x : cur.y)};
              tick_nxt.ar = 1'b1;
            end
          end
          ls6502_pkg::AM_ABS, ls6502_pkg::AM_ABX, ls6502_pkg::AM_ABY: begin
            if (cur.step == 2'd0) begin
              tick_nxt.al = {8'd0, rd};
              tick_nxt.pc = cur.pc + 16'd1;
            end else if (cur.step == 2'd1 && cur.ak == ls6502_pkg::AM_ABS) begin
              tick_nxt.al = {rd, cur.al[7:0]};
              tick_nxt.ar = 1'b1;
              tick_nxt.pc = cur.pc + 16'd1;
            end else begin
              if (cur.step == 2'd1) begin
                base        = {rd, cur.al[7:0]};
                tick_nxt.pc = cur.pc + 16'd1;
              end
              idx    = (cur.ak == ls6502_pkg::AM_ABX) ? cur.x : cur.y;
              first  = 2'd1;
              idx_en = 1'b1;
            end
          end
          ls6502_pkg::AM_INX: begin
            unique case (cur.step)
              2'd0: begin
                tick_nxt.dl = rd;
                tick_nxt.pc = cur.pc + 16'd1;
              end
              2'd1: tick_nxt.dl = cur.dl + cur.x;
              2'd2: begin
                tick_nxt.al = {8'd0, rd};
                tick_nxt.dl = cur.dl + 8'd1;
              end
              default: begin
                tick_nxt.al = {rd, cur.al[7:0]};
                tick_nxt.ar = 1'b1;
              end
            endcase
          end
          ls6502_pkg::AM_INY: begin
            if (cur.step == 2'd0) begin
              tick_nxt.dl = rd;
              tick_nxt.pc = cur.pc + 16'd1;
            end else if (cur.step == 2'd1) begin
              tick_nxt.al = {8'd0, rd};
              tick_nxt.dl = cur.dl + 8'd1;
            end else begin
              if (cur.step == 2'd2) begin
                base = {rd, cur.al[7:0]};
              end
              idx    = cur.y;
              first  = 2'd2;
              idx_en = 1'b1;
            end
          end
          default: begin
            tick_nxt.ar = 1'b1;
            fire        = 1'b1;
          end
        endcase
      end

      if (idx_en) begin
        tick_nxt.al = base;
        low_sum     = {1'b0, base[7:0]} + {1'b0, idx};
        stall       = (cur.step == first) && ((low_sum[8] && cur.pse) || cur.fse);
        if (!stall) begin
          tick_nxt.al = base + {8'd0, idx};
          tick_nxt.ar = 1'b1;
        end
      end

      if (fire) begin
        if (!cur.exe) begin
          unique case (cur.op)
            ls6502_pkg::OP_HLT: begin
              tick_nxt.halt = 1'b1;
              tick_ret      = 1'b1;
            end
            ls6502_pkg::OP_LDA, ls6502_pkg::OP_LDX, ls6502_pkg::OP_LDY: begin
              if (cur.op == ls6502_pkg::OP_LDA) tick_nxt.a = rd;
              if (cur.op == ls6502_pkg::OP_LDX) tick_nxt.x = rd;
              if (cur.op == ls6502_pkg::OP_LDY) tick_nxt.y = rd;
              tick_nxt.p = {rd[7], cur.p[6:2], (rd == 8'd0), cur.p[0]};
            end
            default: tick_nxt.exe = 1'b1;
          endcase
          tick_nxt.exe = 1'b1;
        end else begin
          tick_nxt = do_fetch(tick_nxt, rd);
          tick_ret = 1'b1;
        end
      end

      if (!tick_ret) begin
        tick_nxt.step = cur.step + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cpu_load_store_core_6502_core.sv */
// top level: transaction sequencer, core registers and result register
// A tick, host write or host read transaction drives the single memory port
// when it is accepted in the idle state; the exec state then uses the
// registered read data to update the core (tick only) and loads the result
// register. A core reset reads in turn the vector high byte, the vector low
// byte and the first opcode. A new transaction is taken once the previous one has
// finished and the result register is empty or being read in the same cycle.
`default_nettype none
module cpu_load_store_core_6502_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_retired,
  output logic             out_is_halted,
  output logic [15:0]      out_program_counter,
  output logic [7:0]       out_accumulator,
  output logic [7:0]       out_index_x,
  output logic [7:0]       out_index_y,
  output logic [7:0]       out_status_flags,
  output logic [7:0]       out_stack_pointer,
  output logic [7:0]       out_read_data
);

  ls6502_pkg::seq_t  state_r, state_nxt;
  ls6502_pkg::mode_t mode_r;
  ls6502_pkg::mode_t in_mode_e;
  ls6502_pkg::core_t core_r, core_nxt, tick_nxt, fetch_nxt;
  logic [7:0]  vec_hi_r;
  logic        out_valid_r;
  logic        accept;
  logic        load_out;
  logic [15:0] mem_addr16;
  logic        mem_we;
  logic [7:0]  mem_wd;
  logic [7:0]  rd;
  logic [15:0] iss_addr;
  logic        iss_we;
  logic [7:0]  iss_wd;
  logic        tick_ret;

  assign in_mode_e = ls6502_pkg::mode_t'(in_mode);
  assign in_ready  = (state_r == ls6502_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state_r == ls6502_pkg::S_EXEC) || (state_r == ls6502_pkg::S_RST_FETCH);
  assign out_valid = out_valid_r;

  ls6502_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr16[MEM_ADDR_BITS-1:0]),
    .wd   (mem_wd),
    .rd   (rd)
  );

  ls6502_exec u_exec (
    .cur       (core_r),
    .rd        (rd),
    .iss_addr  (iss_addr),
    .iss_we    (iss_we),
    .iss_wd    (iss_wd),
    .tick_nxt  (tick_nxt),
    .fetch_nxt (fetch_nxt),
    .tick_ret  (tick_ret)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ls6502_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode_e == ls6502_pkg::MODE_RESET) ? ls6502_pkg::S_RST_HI
                                                            : ls6502_pkg::S_EXEC;
        end
      end
      ls6502_pkg::S_EXEC:      state_nxt = ls6502_pkg::S_IDLE;
      ls6502_pkg::S_RST_HI:    state_nxt = ls6502_pkg::S_RST_LO;
      ls6502_pkg::S_RST_LO:    state_nxt = ls6502_pkg::S_RST_FETCH;
      ls6502_pkg::S_RST_FETCH: state_nxt = ls6502_pkg::S_IDLE;
      default:                 state_nxt = ls6502_pkg::S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_addr16 = in_address;
    mem_we     = 1'b0;
    mem_wd     = in_write_data;
    unique case (state_r)
      ls6502_pkg::S_IDLE: begin
        unique case (in_mode_e)
          ls6502_pkg::MODE_TICK: begin
            mem_addr16 = iss_addr;
            mem_we     = accept && iss_we;
            mem_wd     = iss_wd;
          end
          ls6502_pkg::MODE_WRITE: mem_we = accept;
          ls6502_pkg::MODE_READ:  mem_addr16 = in_address;
          ls6502_pkg::MODE_RESET: mem_addr16 = ls6502_pkg::VEC_HI;
        endcase
      end
      ls6502_pkg::S_RST_HI: mem_addr16 = ls6502_pkg::VEC_LO;
      ls6502_pkg::S_RST_LO: mem_addr16 = {vec_hi_r, rd};
      default:              mem_we     = 1'b0;
    endcase
  end

  // core register update
  always_comb begin
    core_nxt = core_r;
    unique case (state_r)
      ls6502_pkg::S_EXEC: begin
        if (mode_r == ls6502_pkg::MODE_TICK) core_nxt = tick_nxt;
      end
      ls6502_pkg::S_RST_LO: begin
        core_nxt.pc   = {vec_hi_r, rd};
        core_nxt.s    = ls6502_pkg::SP_INIT;
        core_nxt.p    = ls6502_pkg::P_INIT;
        core_nxt.halt = 1'b0;
      end
      ls6502_pkg::S_RST_FETCH: core_nxt = fetch_nxt;
      default: core_nxt = core_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ls6502_pkg::S_IDLE;
      core_r      <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= ls6502_pkg::MODE_TICK;
    end else begin
      state_r <= state_nxt;
      core_r  <= core_nxt;
      if (accept) begin
        mode_r <= in_mode_e;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ls6502_pkg::S_RST_HI) begin
      vec_hi_r <= rd;
    end
    if (load_out) begin
      out_retired         <= (state_r == ls6502_pkg::S_EXEC) &&
                             (mode_r == ls6502_pkg::MODE_TICK) && tick_ret;
      out_read_data       <= ((state_r == ls6502_pkg::S_EXEC) &&
                              (mode_r == ls6502_pkg::MODE_READ)) ? rd : 8'd0;
      out_is_halted       <= core_nxt.halt;
      out_program_counter <= core_nxt.pc;
      out_accumulator     <= core_nxt.a;
      out_index_x         <= core_nxt.x;
      out_index_y         <= core_nxt.y;
      out_status_flags    <= core_nxt.p;
      out_stack_pointer   <= core_nxt.s;
    end
  end

endmodule
`default_nettype wire
